// File: rtl/clcd_pkg.sv
// shared types, constants and item script for the char lcd write sequencer
package clcd_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 6;
  localparam int NIB_W    = 4;
  localparam int REG_W    = 20;
  localparam int HOLD_W   = 21;
  localparam int CIDX_W   = 3;
  localparam int STEP_W   = 5;
  localparam int NTERMS   = 5;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = 6'd39;

  // register reset values
  localparam logic [REG_W-1:0] RST_PULSE_HOLD    = 20'd2000;
  localparam logic [REG_W-1:0] RST_BYTE_SETTLE   = 20'd10000;
  localparam logic [REG_W-1:0] RST_POWER_UP_WAIT = 20'd200000;
  localparam logic [REG_W-1:0] RST_LONG_WAIT     = 20'd80000;
  localparam logic [REG_W-1:0] RST_SHORT_WAIT    = 20'd20000;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_COMMAND = 2'd1,
    CMD_DATA    = 2'd2,
    CMD_CURSOR  = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_PULSE_HOLD    = 3'd0,
    CFG_BYTE_SETTLE   = 3'd1,
    CFG_POWER_UP_WAIT = 3'd2,
    CFG_LONG_WAIT     = 3'd3,
    CFG_SHORT_WAIT    = 3'd4
  } cfg_idx_t;

  // cursor address bases
  localparam logic [BYTE_W-1:0] CURSOR_LINE0 = 8'h80;
  localparam logic [BYTE_W-1:0] CURSOR_LINE1 = 8'hC0;

  // hold term bits: which registers sum into one item's hold
  localparam int TERM_P = 0;  // pulse_hold
  localparam int TERM_B = 1;  // byte_settle
  localparam int TERM_U = 2;  // power_up_wait
  localparam int TERM_L = 3;  // long_wait
  localparam int TERM_S = 4;  // short_wait

  localparam logic [NTERMS-1:0] M_P   = 5'b00001;
  localparam logic [NTERMS-1:0] M_PB  = 5'b00011;
  localparam logic [NTERMS-1:0] M_U   = 5'b00100;
  localparam logic [NTERMS-1:0] M_PL  = 5'b01001;
  localparam logic [NTERMS-1:0] M_PS  = 5'b10001;
  localparam logic [NTERMS-1:0] M_PBL = 5'b01011;

  typedef struct packed {
    logic [REG_W-1:0] pulse_hold;
    logic [REG_W-1:0] byte_settle;
    logic [REG_W-1:0] power_up_wait;
    logic [REG_W-1:0] long_wait;
    logic [REG_W-1:0] short_wait;
  } cfg_regs_t;

  typedef struct packed {
    logic              en;
    logic [NIB_W-1:0]  nib;
    logic [NTERMS-1:0] mask;
    logic              last;
  } item_desc_t;

  // accumulator control from sequencer to the shared adder
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_ACC  = 2'd2,
    ST_SHOW = 2'd3
  } seq_state_t;

  // init script: power-up wait, four nibbles, five command bytes
  function automatic item_desc_t init_item(input logic [STEP_W-1:0] step);
    item_desc_t d;
    d = '{en: 1'b0, nib: 4'h0, mask: M_P, last: 1'b0};
    unique case (step)
      5'd0:  d = '{1'b0, 4'h0, M_U,   1'b0};
      5'd1:  d = '{1'b1, 4'h3, M_P,   1'b0};
      5'd2:  d = '{1'b0, 4'h3, M_PL,  1'b0};
      5'd3:  d = '{1'b1, 4'h3, M_P,   1'b0};
      5'd4:  d = '{1'b0, 4'h3, M_PS,  1'b0};
      5'd5:  d = '{1'b1, 4'h3, M_P,   1'b0};
      5'd6:  d = '{1'b0, 4'h3, M_PS,  1'b0};
      5'd7:  d = '{1'b1, 4'h2, M_P,   1'b0};
      5'd8:  d = '{1'b0, 4'h2, M_PS,  1'b0};
      5'd9:  d = '{1'b1, 4'h2, M_P,   1'b0};
      5'd10: d = '{1'b0, 4'h2, M_P,   1'b0};
      5'd11: d = '{1'b1, 4'h8, M_P,   1'b0};
      5'd12: d = '{1'b0, 4'h8, M_PB,  1'b0};
      5'd13: d = '{1'b1, 4'h0, M_P,   1'b0};
      5'd14: d = '{1'b0, 4'h0, M_P,   1'b0};
      5'd15: d = '{1'b1, 4'h8, M_P,   1'b0};
      5'd16: d = '{1'b0, 4'h8, M_PB,  1'b0};
      5'd17: d = '{1'b1, 4'h0, M_P,   1'b0};
      5'd18: d = '{1'b0, 4'h0, M_P,   1'b0};
      5'd19: d = '{1'b1, 4'h1, M_P,   1'b0};
      5'd20: d = '{1'b0, 4'h1, M_PBL, 1'b0};
      5'd21: d = '{1'b1, 4'h0, M_P,   1'b0};
      5'd22: d = '{1'b0, 4'h0, M_P,   1'b0};
      5'd23: d = '{1'b1, 4'h6, M_P,   1'b0};
      5'd24: d = '{1'b0, 4'h6, M_PB,  1'b0};
      5'd25: d = '{1'b1, 4'h0, M_P,   1'b0};
      5'd26: d = '{1'b0, 4'h0, M_P,   1'b0};
      5'd27: d = '{1'b1, 4'hC, M_P,   1'b0};
      5'd28: d = '{1'b0, 4'hC, M_PB,  1'b1};
      default: d = '{1'b0, 4'h0, M_P, 1'b1};
    endcase
    return d;
  endfunction

  // single byte: high nibble pulse, then low nibble pulse plus settle
  function automatic item_desc_t byte_item(input logic [1:0] step,
                                           input logic [BYTE_W-1:0] b);
    item_desc_t d;
    d.en   = ~step[0];
    d.nib  = step[1] ? b[3:0] : b[7:4];
    d.mask = (step == 2'd3) ? M_PB : M_P;
    d.last = (step == 2'd3);
    return d;
  endfunction

endpackage

// File: rtl/clcd_in_if.sv
// request channel interface
interface clcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [clcd_pkg::CMD_W-1:0]  cmd;
  logic [clcd_pkg::BYTE_W-1:0] value;
  logic                        row;
  logic [clcd_pkg::COL_W-1:0]  column;

  modport source (output valid, cmd, value, row, column, input ready);
  modport sink   (input valid, cmd, value, row, column, output ready);
endinterface

// File: rtl/clcd_out_if.sv
// pin-state result channel interface
interface clcd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        reg_select;
  logic                        enable_pin;
  logic [clcd_pkg::NIB_W-1:0]  data_nibble;
  logic [clcd_pkg::HOLD_W-1:0] hold_count;
  logic                        last;

  modport source (output valid, reg_select, enable_pin, data_nibble, hold_count, last,
                  input ready);
  modport sink   (input valid, reg_select, enable_pin, data_nibble, hold_count, last,
                  output ready);
endinterface

// File: rtl/clcd_cfg_if.sv
// configuration write channel interface
interface clcd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [clcd_pkg::CIDX_W-1:0] index;
  logic [clcd_pkg::REG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/char_lcd_4bit_write_sequencer_core.sv
// top level of the 4-bit character lcd write sequencer
// an item runs a load step, an adder step for each hold term and one more adder step,
// then holds its result word until taken; a byte request gives 4 words, init 29
// words; the request channel is ready again the cycle after the last word is taken
// synchronous active-low reset: sequencer idle, timing registers at their defaults
module char_lcd_4bit_write_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  clcd_in_if.sink    in_ch,
  clcd_out_if.source out_ch,
  clcd_cfg_if.sink   cfg_ch
);
  import clcd_pkg::*;

  cfg_regs_t         regs;
  acc_ctl_t          acc_ctl;
  logic [REG_W-1:0]  acc_operand;
  logic [HOLD_W-1:0] acc;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  clcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .regs     (regs)
  );

  clcd_sat_acc u_acc (
    .clk     (clk),
    .ctl     (acc_ctl),
    .operand (acc_operand),
    .acc     (acc)
  );

  clcd_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_cmd          (in_ch.cmd),
    .in_value        (in_ch.value),
    .in_row          (in_ch.row),
    .in_column       (in_ch.column),
    .regs            (regs),
    .acc_ctl         (acc_ctl),
    .acc_operand     (acc_operand),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_reg_select  (out_ch.reg_select),
    .out_enable_pin  (out_ch.enable_pin),
    .out_data_nibble (out_ch.data_nibble),
    .out_last        (out_ch.last)
  );

  // hold comes straight from the accumulator, stable while the word waits
  assign out_ch.hold_count = acc;
endmodule

// File: rtl/clcd_cfg_regs.sv
// timing register file written through the configuration channel
module clcd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [clcd_pkg::CIDX_W-1:0] wr_index,
  input  logic [clcd_pkg::REG_W-1:0]  wr_data,
  output clcd_pkg::cfg_regs_t         regs
);
  import clcd_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // decode the write, unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PULSE_HOLD:    regs_nxt.pulse_hold    = wr_data;
        CFG_BYTE_SETTLE:   regs_nxt.byte_settle   = wr_data;
        CFG_POWER_UP_WAIT: regs_nxt.power_up_wait = wr_data;
        CFG_LONG_WAIT:     regs_nxt.long_wait     = wr_data;
        CFG_SHORT_WAIT:    regs_nxt.short_wait    = wr_data;
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pulse_hold    <= RST_PULSE_HOLD;
      regs_r.byte_settle   <= RST_BYTE_SETTLE;
      regs_r.power_up_wait <= RST_POWER_UP_WAIT;
      regs_r.long_wait     <= RST_LONG_WAIT;
      regs_r.short_wait    <= RST_SHORT_WAIT;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;
endmodule

// File: rtl/clcd_sat_acc.sv
// shared saturating hold accumulator, one term added per cycle while add is set
module clcd_sat_acc (
  input  logic                        clk,
  input  clcd_pkg::acc_ctl_t          ctl,
  input  logic [clcd_pkg::REG_W-1:0]  operand,
  output logic [clcd_pkg::HOLD_W-1:0] acc
);
  import clcd_pkg::*;

  logic [HOLD_W-1:0] acc_r;
  logic [HOLD_W-1:0] acc_nxt;
  logic [HOLD_W:0]   sum;

  // add with clamp at the hold field maximum
  always_comb begin
    sum     = {1'b0, acc_r} + {{(HOLD_W+1-REG_W){1'b0}}, operand};
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = sum[HOLD_W] ? HOLD_MAX : sum[HOLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

// File: rtl/clcd_seq.sv
// item sequencer: walks the script, feeds the adder, holds the result word
module clcd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [clcd_pkg::CMD_W-1:0]  in_cmd,
  input  logic [clcd_pkg::BYTE_W-1:0] in_value,
  input  logic                        in_row,
  input  logic [clcd_pkg::COL_W-1:0]  in_column,
  input  clcd_pkg::cfg_regs_t         regs,
  output clcd_pkg::acc_ctl_t          acc_ctl,
  output logic [clcd_pkg::REG_W-1:0]  acc_operand,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_reg_select,
  output logic                        out_enable_pin,
  output logic [clcd_pkg::NIB_W-1:0]  out_data_nibble,
  output logic                        out_last
);
  import clcd_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              init_r, init_nxt;
  logic              rs_r, rs_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [NTERMS-1:0] mask_r, mask_nxt;
  logic              en_r, en_nxt;
  logic [NIB_W-1:0]  nib_r, nib_nxt;
  logic              last_r, last_nxt;

  item_desc_t        desc;
  logic [COL_W-1:0]  col_clamp;
  logic [BYTE_W-1:0] cursor_byte;

  // cursor address, column clamped to the last column of a line
  always_comb begin
    col_clamp   = (in_column > COL_MAX) ? COL_MAX : in_column;
    cursor_byte = (in_row ? CURSOR_LINE1 : CURSOR_LINE0) | {2'b00, col_clamp};
  end

  // item descriptor for the current step
  always_comb begin
    if (init_r) begin
      desc = init_item(step_r);
    end else begin
      desc = byte_item(step_r[1:0], byte_r);
    end
  end

  // next state and controls
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    init_nxt    = init_r;
    rs_nxt      = rs_r;
    byte_nxt    = byte_r;
    mask_nxt    = mask_r;
    en_nxt      = en_r;
    nib_nxt     = nib_r;
    last_nxt    = last_r;
    acc_ctl     = '{clr: 1'b0, add: 1'b0};
    acc_operand = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          step_nxt  = '0;
          init_nxt  = (in_cmd == CMD_INIT);
          rs_nxt    = (in_cmd == CMD_DATA);
          byte_nxt  = (in_cmd == CMD_CURSOR) ? cursor_byte : in_value;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mask_nxt    = desc.mask;
        en_nxt      = desc.en;
        nib_nxt     = desc.nib;
        last_nxt    = desc.last;
        acc_ctl.clr = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        // lowest pending term goes through the adder
        acc_ctl.add = (mask_r != '0);
        priority if (mask_r[TERM_P]) begin
          acc_operand      = regs.pulse_hold;
          mask_nxt[TERM_P] = 1'b0;
        end else if (mask_r[TERM_B]) begin
          acc_operand      = regs.byte_settle;
          mask_nxt[TERM_B] = 1'b0;
        end else if (mask_r[TERM_U]) begin
          acc_operand      = regs.power_up_wait;
          mask_nxt[TERM_U] = 1'b0;
        end else if (mask_r[TERM_L]) begin
          acc_operand      = regs.long_wait;
          mask_nxt[TERM_L] = 1'b0;
        end else if (mask_r[TERM_S]) begin
          acc_operand      = regs.short_wait;
          mask_nxt[TERM_S] = 1'b0;
        end else begin
          state_nxt = ST_SHOW;
        end
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request and item registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    init_r <= init_nxt;
    rs_r   <= rs_nxt;
    byte_r <= byte_nxt;
    mask_r <= mask_nxt;
    en_r   <= en_nxt;
    nib_r  <= nib_nxt;
    last_r <= last_nxt;
  end

  assign out_reg_select  = rs_r;
  assign out_enable_pin  = en_r;
  assign out_data_nibble = nib_r;
  assign out_last        = last_r;
endmodule

// File: rtl/clcd_checker.sv
// port-level checks for the lcd write sequencer, bound to the top level
module clcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_enable_pin,
  input logic [clcd_pkg::NIB_W-1:0]  out_data_nibble,
  input logic [clcd_pkg::HOLD_W-1:0] out_hold_count,
  input logic                        out_last
);
  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hold_count)
      && $stable(out_data_nibble) && $stable(out_last))
    else $error("stalled result word changed");

  // busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // no request taken while a word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request ready with a word pending");

  // run continues after a non-final word
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("run ended before its last word");

  // a run never ends with enable high
  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enable_pin |-> !out_last)
    else $error("last word with enable high");
endmodule

bind char_lcd_4bit_write_sequencer_core clcd_checker u_clcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_enable_pin  (out_ch.enable_pin),
  .out_data_nibble (out_ch.data_nibble),
  .out_hold_count  (out_ch.hold_count),
  .out_last        (out_ch.last)
);

// File: bench/char_lcd_4bit_write_sequencer_core_test.sv
// self-checking testbench for the 4-bit character lcd write sequencer core
module char_lcd_4bit_write_sequencer_core_test;
  import clcd_pkg::*;

  localparam int SUM_W          = HOLD_W + 2;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 40;
  localparam longint RUN_LIMIT  = 64'd10_000_000;

  // register select levels
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // init script contents
  localparam logic [NIB_W-1:0]  WAKE_NIBBLE      = 4'h3;
  localparam logic [NIB_W-1:0]  BUS4_NIBBLE      = 4'h2;
  localparam logic [BYTE_W-1:0] LCD_FUNCTION_SET = 8'h28;
  localparam logic [BYTE_W-1:0] LCD_DISPLAY_OFF  = 8'h08;
  localparam logic [BYTE_W-1:0] LCD_CLEAR        = 8'h01;
  localparam logic [BYTE_W-1:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [BYTE_W-1:0] LCD_DISPLAY_ON   = 8'h0C;

  localparam logic [COL_W-1:0]  COL_TOP         = {COL_W{1'b1}};
  localparam logic [REG_W-1:0]  REG_TOP         = {REG_W{1'b1}};
  localparam logic [CIDX_W-1:0] CFG_SPARE_INDEX = {CIDX_W{1'b1}};

  typedef logic [SUM_W-1:0] hold_sum_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] value;
    logic              row;
    logic [COL_W-1:0]  column;
  } lcd_req_t;

  typedef struct packed {
    logic              rs;
    logic              en;
    logic [NIB_W-1:0]  nib;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } pin_word_t;

  // expected pin words per request, checked in order against the block
  class lcd_pin_predictor;
    logic [REG_W-1:0] t_pulse;
    logic [REG_W-1:0] t_settle;
    logic [REG_W-1:0] t_power_up;
    logic [REG_W-1:0] t_long;
    logic [REG_W-1:0] t_short;
    pin_word_t pending_words[$];
    int unsigned mismatches;

    function new();
      t_pulse    = RST_PULSE_HOLD;
      t_settle   = RST_BYTE_SETTLE;
      t_power_up = RST_POWER_UP_WAIT;
      t_long     = RST_LONG_WAIT;
      t_short    = RST_SHORT_WAIT;
      mismatches = 0;
    endfunction

    function void set_register(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_PULSE_HOLD:    t_pulse    = val;
        CFG_BYTE_SETTLE:   t_settle   = val;
        CFG_POWER_UP_WAIT: t_power_up = val;
        CFG_LONG_WAIT:     t_long     = val;
        CFG_SHORT_WAIT:    t_short    = val;
        default: ;
      endcase
    endfunction

    // one pin word, hold clipped at the top of the hold field
    function void add_pin_word(logic rs, logic en, logic [NIB_W-1:0] nib, hold_sum_t hold);
      pin_word_t w;
      w.rs   = rs;
      w.en   = en;
      w.nib  = nib;
      w.hold = (hold > hold_sum_t'(HOLD_MAX)) ? HOLD_MAX : hold[HOLD_W-1:0];
      w.last = 1'b0;
      pending_words.push_back(w);
    endfunction

    // enable high then enable low, extra wait on the low phase
    function void add_pulse(logic rs, logic [NIB_W-1:0] nib, hold_sum_t extra);
      add_pin_word(rs, 1'b1, nib, hold_sum_t'(t_pulse));
      add_pin_word(rs, 1'b0, nib, hold_sum_t'(t_pulse) + extra);
    endfunction

    // high nibble first, settle time after the low nibble
    function void add_byte(logic rs, logic [BYTE_W-1:0] b, logic [REG_W-1:0] extra);
      add_pulse(rs, b[7:4], '0);
      add_pulse(rs, b[3:0], hold_sum_t'(t_settle) + hold_sum_t'(extra));
    endfunction

    function void note_request(lcd_req_t r);
      pin_word_t w;
      logic [COL_W-1:0] col;
      case (r.cmd)
        CMD_INIT: begin
          add_pin_word(RS_COMMAND, 1'b0, '0, hold_sum_t'(t_power_up));
          add_pulse(RS_COMMAND, WAKE_NIBBLE, hold_sum_t'(t_long));
          add_pulse(RS_COMMAND, WAKE_NIBBLE, hold_sum_t'(t_short));
          add_pulse(RS_COMMAND, WAKE_NIBBLE, hold_sum_t'(t_short));
          add_pulse(RS_COMMAND, BUS4_NIBBLE, hold_sum_t'(t_short));
          add_byte(RS_COMMAND, LCD_FUNCTION_SET, '0);
          add_byte(RS_COMMAND, LCD_DISPLAY_OFF, '0);
          add_byte(RS_COMMAND, LCD_CLEAR, t_long);
          add_byte(RS_COMMAND, LCD_ENTRY_MODE, '0);
          add_byte(RS_COMMAND, LCD_DISPLAY_ON, '0);
        end
        CMD_COMMAND: add_byte(RS_COMMAND, r.value, '0);
        CMD_DATA:    add_byte(RS_DATA, r.value, '0);
        default: begin
          // columns past the end of a line land on the last column
          col = (r.column > COL_MAX) ? COL_MAX : r.column;
          add_byte(RS_COMMAND, (r.row ? CURSOR_LINE1 : CURSOR_LINE0) + {2'b00, col}, '0);
        end
      endcase
      w = pending_words.pop_back();
      w.last = 1'b1;
      pending_words.push_back(w);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
      end
    endfunction

    function void check_word(pin_word_t got);
      pin_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing expected, got rs %0d en %0d nib %0h hold %0d last %0d",
                 $time, got.rs, got.en, got.nib, got.hold, got.last);
        return;
      end
      want = pending_words.pop_front();
      compare_field("reg_select", want.rs, got.rs);
      compare_field("enable_pin", want.en, got.en);
      compare_field("data_nibble", want.nib, got.nib);
      compare_field("hold_count", want.hold, got.hold);
      compare_field("last", want.last, got.last);
    endfunction

    function int unsigned outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_off_req;
  lcd_pin_predictor lcd_pins;

  clcd_in_if  in_ch();
  clcd_out_if out_ch();
  clcd_cfg_if cfg_ch();

  char_lcd_4bit_write_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result sink: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check every word taken from the block
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      lcd_pins.check_word({out_ch.reg_select, out_ch.enable_pin, out_ch.data_nibble,
                           out_ch.hold_count, out_ch.last});
  end

  task automatic offer_request(lcd_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= r.cmd;
    in_ch.value  <= r.value;
    in_ch.row    <= r.row;
    in_ch.column <= r.column;
    do @(posedge clk); while (!in_ch.ready);
    lcd_pins.note_request(r);
  endtask

  task automatic offer_fields(cmd_t c, logic [BYTE_W-1:0] v, logic rw, logic [COL_W-1:0] col);
    lcd_req_t r;
    r.cmd    = c;
    r.value  = v;
    r.row    = rw;
    r.column = col;
    offer_request(r);
  endtask

  // stop offering and wait for every expected word
  task automatic wait_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (lcd_pins.outstanding() != 0) @(posedge clk);
  endtask

  task automatic drain_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    lcd_pins.set_register(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(logic [REG_W-1:0] p, logic [REG_W-1:0] b, logic [REG_W-1:0] u,
                           logic [REG_W-1:0] l, logic [REG_W-1:0] s);
    write_register(CFG_PULSE_HOLD, p);
    write_register(CFG_BYTE_SETTLE, b);
    write_register(CFG_POWER_UP_WAIT, u);
    write_register(CFG_LONG_WAIT, l);
    write_register(CFG_SHORT_WAIT, s);
  endtask

  // extremes often, otherwise anything in range
  function automatic logic [REG_W-1:0] pick_setting();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return REG_TOP;
      default: return raw[REG_W-1:0];
    endcase
  endfunction

  task automatic random_settings();
    for (int i = CFG_PULSE_HOLD; i <= CFG_SHORT_WAIT; i++)
      write_register(i[CIDX_W-1:0], pick_setting());
  endtask

  // init is kept rare since it costs 29 words
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    case ($urandom_range(0, 9))
      0:       r.cmd = CMD_INIT;
      1, 2, 3: r.cmd = CMD_COMMAND;
      4, 5, 6: r.cmd = CMD_DATA;
      default: r.cmd = CMD_CURSOR;
    endcase
    r.value = BYTE_W'($urandom_range(0, 255));
    r.row   = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0)
      r.column = COL_W'($urandom_range(COL_MAX + 1, COL_TOP));
    else
      r.column = COL_W'($urandom_range(0, COL_MAX));
    return r;
  endfunction

  initial begin
    lcd_pins       = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_INIT;
    in_ch.value    = '0;
    in_ch.row      = 1'b0;
    in_ch.column   = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_PULSE_HOLD;
    cfg_ch.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every request at reset timing, with unused fields set to odd values
    offer_fields(CMD_INIT, 8'hFF, 1'b1, COL_TOP);
    offer_fields(CMD_COMMAND, 8'h00, 1'b1, COL_TOP);
    offer_fields(CMD_COMMAND, 8'hFF, 1'b0, 6'd0);
    offer_fields(CMD_DATA, 8'h00, 1'b0, 6'd0);
    offer_fields(CMD_DATA, 8'hFF, 1'b1, 6'd0);
    offer_fields(CMD_DATA, 8'hA5, 1'b0, 6'd21);
    offer_fields(CMD_COMMAND, 8'h5A, 1'b1, 6'd42);
    offer_fields(CMD_CURSOR, 8'hFF, 1'b0, 6'd0);
    offer_fields(CMD_CURSOR, 8'h00, 1'b0, COL_MAX);
    offer_fields(CMD_CURSOR, 8'h3C, 1'b1, 6'd0);
    offer_fields(CMD_CURSOR, 8'hC3, 1'b1, COL_MAX);
    offer_fields(CMD_CURSOR, 8'h00, 1'b0, 6'd40);
    offer_fields(CMD_CURSOR, 8'hFF, 1'b1, COL_TOP);
    offer_fields(CMD_CURSOR, 8'h00, 1'b0, 6'd42);

    // all registers at the top: only a three-term hold clips, one- and two-term holds fit
    drain_block();
    write_all(REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
    offer_fields(CMD_INIT, 8'h00, 1'b0, 6'd0);
    offer_fields(CMD_DATA, 8'hFF, 1'b0, 6'd0);
    offer_fields(CMD_CURSOR, 8'h00, 1'b1, COL_TOP);

    // zero holds pass straight through
    drain_block();
    write_all('0, '0, '0, '0, '0);
    offer_fields(CMD_INIT, 8'h55, 1'b1, 6'd5);
    offer_fields(CMD_COMMAND, 8'h3C, 1'b0, 6'd0);

    // shortest pulse; a write to an unused index changes nothing
    drain_block();
    write_all(20'd1, '0, '0, '0, '0);
    write_register(CFG_SPARE_INDEX, REG_TOP);
    offer_fields(CMD_INIT, 8'h00, 1'b0, 6'd0);
    offer_fields(CMD_DATA, 8'h81, 1'b1, 6'd17);

    drain_block();
    write_all(RST_PULSE_HOLD, RST_BYTE_SETTLE, RST_POWER_UP_WAIT, RST_LONG_WAIT,
              RST_SHORT_WAIT);

    // random requests over several timing settings and idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_block();
      if (phase != 0)
        random_settings();
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      // sink holds off long enough for the request side to back up
      if (phase == 2) begin
        @(posedge clk);
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2)
          wait_results();
        offer_request(random_request());
      end
    end

    drain_block();
    if (lcd_pins.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: char_lcd_4bit_write_sequencer_core.f
rtl/clcd_pkg.sv
rtl/clcd_in_if.sv
rtl/clcd_out_if.sv
rtl/clcd_cfg_if.sv
rtl/clcd_cfg_regs.sv
rtl/clcd_sat_acc.sv
rtl/clcd_seq.sv
rtl/char_lcd_4bit_write_sequencer_core.sv
rtl/clcd_checker.sv
bench/char_lcd_4bit_write_sequencer_core_test.sv
